### design/gtg_pkg.sv
package gtg_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_ENTRIES = 24;
  localparam int STEPS_USED = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;

  localparam int POS_W = 16;
  localparam int GAIN_W = 12;
  localparam int LIN_W = 15;
  localparam int DIFF_W = POS_W + 1;
  localparam int VEC_W = 28;
  localparam int ANG_W = 35;
  localparam int ERR_W = 37;
  localparam int STEP_W = 5;

  localparam logic signed [POS_W-1:0] GOAL_LIMIT = 16'sd22528;
  localparam logic [29:0] INV_GAIN_Q30 = 30'd652032875;
  localparam logic signed [ANG_W-1:0] PI_Q30 = 35'sd3373259426;

  localparam logic [GAIN_W-1:0] LINEAR_GAIN_RESET = 12'd256;
  localparam logic [GAIN_W-1:0] ANGULAR_GAIN_RESET = 12'd1536;

  typedef enum logic [1:0] {
    ACT_GOAL = 2'd0,
    ACT_POSE = 2'd1,
    ACT_TICK = 2'd2,
    ACT_NONE = 2'd3
  } action_t;

  localparam logic REG_LINEAR_GAIN = 1'b0;
  localparam logic REG_ANGULAR_GAIN = 1'b1;

  function automatic logic [29:0] atan_q30(input logic [STEP_W-1:0] i);
    logic [29:0] v;
    unique case (i)
      5'd0: v = 30'd843314857;
      5'd1: v = 30'd497837830;
      5'd2: v = 30'd263043837;
      5'd3: v = 30'd133525159;
      5'd4: v = 30'd67021687;
      5'd5: v = 30'd33543515;
      5'd6: v = 30'd16775851;
      5'd7: v = 30'd8388438;
      5'd8: v = 30'd4194283;
      5'd9: v = 30'd2097150;
      5'd10: v = 30'd1048576;
      5'd11: v = 30'd524288;
      5'd12: v = 30'd262144;
      5'd13: v = 30'd131072;
      5'd14: v = 30'd65536;
      5'd15: v = 30'd32768;
      5'd16: v = 30'd16384;
      5'd17: v = 30'd8192;
      5'd18: v = 30'd4096;
      5'd19: v = 30'd2048;
      5'd20: v = 30'd1024;
      5'd21: v = 30'd512;
      5'd22: v = 30'd256;
      5'd23: v = 30'd128;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

### design/gtg_if.sv
interface gtg_cmd_if
  import gtg_pkg::*;
();
  logic valid;
  logic ready;
  logic [1:0] action;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic signed [POS_W-1:0] heading;

  modport source (output valid, action, pos_x, pos_y, heading, input ready);
  modport sink (input valid, action, pos_x, pos_y, heading, output ready);
endinterface

interface gtg_speed_if
  import gtg_pkg::*;
();
  logic valid;
  logic ready;
  logic [LIN_W-1:0] linear_speed;
  logic signed [POS_W-1:0] angular_speed;

  modport source (output valid, linear_speed, angular_speed, input ready);
  modport sink (input valid, linear_speed, angular_speed, output ready);
endinterface

### design/go_to_goal_p_controller.sv
// Proportional go-to-goal controller for a planar robot.
// Commands arrive on the cmd channel, one transaction per command. A goal
// command stores the goal, each coordinate limited to at most 11.0, and
// is taken with cmd.ready staying high. A pose command stores position
// and heading and refreshes the goal distance; a tick command produces
// one speed transaction on the speed channel. Pose and tick commands run
// a vectoring CORDIC on one shared add/shift unit, one step per cycle,
// so cmd.ready is low while the CORDIC steps (S_ITER), the multiply
// (S_MUL) and the final state (S_FIN) run. For a tick, the result goes
// from S_FIN into the speed output register, which raises speed.valid.
// The speed output is a register: a finished result waits there while the
// receiver stalls, and the block keeps accepting commands. A second tick
// that completes while the first result is still held waits until the
// speed transaction completes. Gains are written through wr_en, wr_index
// and wr_data; the user must write them only while the block is idle, as
// the block itself does not enforce it. Synchronous reset restores the
// gains to 1.0 and 6.0 and clears goal, pose and distance to zero.
module go_to_goal_p_controller
  import gtg_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  gtg_cmd_if.sink           cmd,
  gtg_speed_if.source       speed,
  input  logic              wr_en,
  input  logic              wr_index,
  input  logic [GAIN_W-1:0] wr_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ITER,
    S_MUL,
    S_FIN
  } state_t;

  state_t state;
  logic [GAIN_W-1:0] linear_gain;
  logic [GAIN_W-1:0] angular_gain;
  logic signed [POS_W-1:0] goal_x;
  logic signed [POS_W-1:0] goal_y;
  logic signed [POS_W-1:0] robot_x;
  logic signed [POS_W-1:0] robot_y;
  logic signed [POS_W-1:0] robot_heading;
  logic [POS_W-1:0] goal_distance;

  logic is_tick;
  logic vec_zero;
  logic [STEP_W-1:0] step;
  logic signed [VEC_W-1:0] vx;
  logic signed [VEC_W-1:0] vy;
  logic signed [ANG_W-1:0] vz;
  logic [56:0] mag_prod;
  logic signed [49:0] ang_prod;

  logic out_valid;
  logic [LIN_W-1:0] out_lin;
  logic signed [POS_W-1:0] out_ang;

  logic accept;
  action_t act;
  logic signed [POS_W-1:0] src_x;
  logic signed [POS_W-1:0] src_y;
  logic signed [DIFF_W-1:0] dx;
  logic signed [DIFF_W-1:0] dy;
  logic signed [VEC_W-1:0] x0;
  logic signed [VEC_W-1:0] y0;
  logic signed [VEC_W-1:0] xs;
  logic signed [VEC_W-1:0] ys;
  logic signed [ANG_W-1:0] step_ang;
  logic signed [ERR_W-1:0] err;
  logic [20:0] mag_full;
  logic [POS_W-1:0] mag;
  logic [28:0] lin_full;
  logic [LIN_W-1:0] lin;
  logic signed [20:0] angv_full;
  logic signed [POS_W-1:0] angv;

  assign cmd.ready = (state == S_IDLE);
  assign accept = cmd.valid && cmd.ready;
  assign act = action_t'(cmd.action);

  assign speed.valid = out_valid;
  assign speed.linear_speed = out_lin;
  assign speed.angular_speed = out_ang;

  always_comb begin
    src_x = (act == ACT_POSE) ? cmd.pos_x : robot_x;
    src_y = (act == ACT_POSE) ? cmd.pos_y : robot_y;
    dx = DIFF_W'(goal_x) - DIFF_W'(src_x);
    dy = DIFF_W'(goal_y) - DIFF_W'(src_y);
    x0 = VEC_W'(dx) <<< 8;
    y0 = VEC_W'(dy) <<< 8;

    xs = vx >>> step;
    ys = vy >>> step;
    step_ang = ANG_W'(atan_q30(step));

    err = (vec_zero ? ERR_W'(0) : ERR_W'(vz)) - (ERR_W'(robot_heading) <<< 17);

    mag_full = 21'(mag_prod + (57'd1 << 37) >> 38);
    mag = (mag_full > 21'd65535) ? 16'hFFFF : mag_full[POS_W-1:0];

    lin_full = 29'(({17'd0, linear_gain} * {13'd0, goal_distance}) + 29'd128) >> 8;
    lin = (lin_full > 29'd32767) ? 15'h7FFF : lin_full[LIN_W-1:0];

    angv_full = 21'((ang_prod + (50'sd1 <<< 28)) >>> 29);
    if (angv_full > 21'sd32767) begin
      angv = 16'sh7FFF;
    end else if (angv_full < -21'sd32768) begin
      angv = -16'sh8000;
    end else begin
      angv = angv_full[POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      linear_gain <= LINEAR_GAIN_RESET;
      angular_gain <= ANGULAR_GAIN_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_LINEAR_GAIN: linear_gain <= wr_data;
        REG_ANGULAR_GAIN: angular_gain <= wr_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      goal_x <= '0;
      goal_y <= '0;
      robot_x <= '0;
      robot_y <= '0;
      robot_heading <= '0;
      goal_distance <= '0;
      out_valid <= 1'b0;
      is_tick <= 1'b0;
      vec_zero <= 1'b0;
      step <= '0;
    end else begin
      if (state == S_FIN && is_tick && (!out_valid || speed.ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && speed.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (act)
              ACT_GOAL: begin
                goal_x <= (cmd.pos_x > GOAL_LIMIT) ? GOAL_LIMIT : cmd.pos_x;
                goal_y <= (cmd.pos_y > GOAL_LIMIT) ? GOAL_LIMIT : cmd.pos_y;
              end
              ACT_POSE, ACT_TICK: begin
                if (act == ACT_POSE) begin
                  robot_x <= cmd.pos_x;
                  robot_y <= cmd.pos_y;
                  robot_heading <= cmd.heading;
                end
                is_tick <= (act == ACT_TICK);
                vec_zero <= (dx == '0) && (dy == '0);
                step <= '0;
                if (dx < 0) begin
                  vx <= -x0;
                  vy <= -y0;
                  vz <= (dy >= 0) ? PI_Q30 : -PI_Q30;
                end else begin
                  vx <= x0;
                  vy <= y0;
                  vz <= '0;
                end
                state <= S_ITER;
              end
              ACT_NONE: ;
              default: ;
            endcase
          end
        end
        S_ITER: begin
          if (vy > 0) begin
            vx <= vx + ys;
            vy <= vy - xs;
            vz <= vz + step_ang;
          end else begin
            vx <= vx - ys;
            vy <= vy + xs;
            vz <= vz - step_ang;
          end
          step <= step + 1'b1;
          if (step == STEP_W'(STEPS_USED - 1)) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          mag_prod <= {30'd0, vx[26:0]} * {27'd0, INV_GAIN_Q30};
          ang_prod <= 50'($signed({1'b0, angular_gain})) * 50'(err);
          state <= S_FIN;
        end
        S_FIN: begin
          if (!is_tick) begin
            goal_distance <= vec_zero ? '0 : mag;
            state <= S_IDLE;
          end else if (!out_valid || speed.ready) begin
            out_lin <= lin;
            out_ang <= angv;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_busy_after_cordic_cmd: assert property (@(posedge clk) disable iff (rst)
    accept && (act == ACT_POSE || act == ACT_TICK) |=> !cmd.ready)
    else $error("cmd.ready stayed high after a pose or tick command");

  a_step_in_range: assert property (@(posedge clk) disable iff (rst)
    state == S_ITER |-> step < STEP_W'(STEPS_USED))
    else $error("CORDIC step counter out of range");

  a_x_nonneg: assert property (@(posedge clk) disable iff (rst)
    state == S_MUL |-> !vx[VEC_W-1])
    else $error("CORDIC magnitude register went negative");

  a_result_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_FIN) && $past(is_tick))
    else $error("speed result raised outside a finished tick");

endmodule
